[design/assert_macros.svh]
// Assertion macros used by the sequencer design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[design/mts_pkg.sv]
// Types and constants of the memory test sequencer.
package mts_pkg;
	localparam int unsigned MaxRegionBytes = 1048576;

	typedef enum logic [2:0] {
		K_MARCH = 3'd0,
		K_WALK  = 3'd1,
		K_ADDR  = 3'd2,
		K_DATA  = 3'd3,
		K_QUICK = 3'd4,
		K_FULL  = 3'd5
	} test_kind_t;

	localparam logic [2:0] WalkPhase   = 3'd6;
	localparam logic [3:0] NumPatterns = 4'd8;
	localparam logic [7:0] PatZero     = 8'h00;
	localparam logic [7:0] PatOne      = 8'hFF;
	localparam logic [7:0] PatQuick    = 8'h55;

	localparam logic [1:0] OUT_WRITE   = 2'd0;
	localparam logic [1:0] OUT_READ    = 2'd1;
	localparam logic [1:0] OUT_VERDICT = 2'd2;

	localparam logic [1:0] V_PASS   = 2'd0;
	localparam logic [1:0] V_FAIL   = 2'd1;
	localparam logic [1:0] V_REJECT = 2'd2;

	typedef struct packed {
		logic        rd;
		logic        chk;
		logic [31:0] addr;
		logic [7:0]  data;
	} access_t;

	function automatic logic [7:0] walk_pattern(input logic [2:0] idx);
		logic [7:0] p;
		case (idx)
			3'd0: p = 8'h00;
			3'd1: p = 8'hFF;
			3'd2: p = 8'h55;
			3'd3: p = 8'hAA;
			3'd4: p = 8'h01;
			3'd5: p = 8'hFE;
			3'd6: p = 8'h80;
			default: p = 8'h7F;
		endcase
		return p;
	endfunction
endpackage

[design/memory_test_sequencer.sv]
// Top level of the byte-wide memory test sequencer.
// A start item (tuser = 0) names a test kind, a region start and a region size; the block
// answers with the first memory command, or with a rejected verdict when the start is
// misaligned, the size is zero or above MAX_REGION_BYTES, the kind is unknown or a test
// already runs. Each acknowledge item (tuser = 1) carries the byte of a completed read and
// yields the next command, or the final verdict: pass after the last access, mismatch at the
// first wrong read (with address, expected and actual byte). Acknowledges while idle give
// nothing. Every item is handled by next-state logic between the state
// registers and one output register, so one item per clock is taken as long as the output
// register is empty or drained in the same cycle; the output register is the only stage.
`include "assert_macros.svh"

module memory_test_sequencer #(
	parameter int unsigned MAX_REGION_BYTES = mts_pkg::MaxRegionBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// test_kind[2:0], region_start[34:3], region_size[55:35], read_data[63:56]
	input  logic [63:0] s_tdata,
	// op[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// access_addr[31:0], write_data[39:32], verdict[41:40], fail_addr[73:42],
	// expected_byte[81:74], actual_byte[89:82], zero fill above
	output logic [95:0] m_tdata,
	// kind[1:0]
	output logic [1:0]  m_tuser
);
	// Sequencer state.
	logic        busy_q;
	logic [2:0]  run_kind_q;
	logic [2:0]  elem_q;
	logic [1:0]  step_q;
	logic [20:0] byte_idx_q;
	logic [3:0]  pat_idx_q;
	logic [31:0] base_q;
	logic [20:0] len_q;
	logic [7:0]  saved_q;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [95:0] out_data_q;

	// Decoded input item.
	logic        in_acc;
	logic [2:0]  in_kind;
	logic [31:0] in_start;
	logic [20:0] in_size;
	logic [7:0]  in_rdata;

	// Next state and result.
	logic        n_busy;
	logic [2:0]  n_kind;
	logic [2:0]  n_elem;
	logic [1:0]  n_step;
	logic [20:0] n_bidx;
	logic [3:0]  n_pidx;
	logic [31:0] n_base;
	logic [20:0] n_len;
	logic [7:0]  n_saved;
	logic        has_res;
	logic        res_cmd;
	logic [1:0]  res_verdict;
	logic [31:0] res_fail;
	logic [7:0]  res_exp;
	logic [7:0]  res_act;
	logic        cont;
	logic [21:0] bidx_inc;

	mts_pkg::access_t cur_op;
	mts_pkg::access_t nxt_op;

	// The access that a given state stands for.
	function automatic mts_pkg::access_t op_of(
		input logic [2:0]  kind,
		input logic [2:0]  e,
		input logic [1:0]  s,
		input logic [20:0] bi,
		input logic [3:0]  pi,
		input logic [31:0] base,
		input logic [20:0] len,
		input logic [7:0]  saved
	);
		mts_pkg::access_t a;
		logic [20:0] off;
		logic [7:0]  first;
		a.rd   = 1'b0;
		a.chk  = 1'b1;
		a.addr = base;
		a.data = mts_pkg::PatZero;
		off    = (e >= 3'd3) ? (len - 21'd1 - bi) : bi;
		first  = (e == 3'd2 || e == 3'd4) ? mts_pkg::PatOne : mts_pkg::PatZero;
		if (e == mts_pkg::WalkPhase) begin
			a.data = mts_pkg::walk_pattern(pi[2:0]);
			a.rd   = s[1];
			if (s[0]) begin
				a.addr = base + 32'(len) - 32'd1;
			end
		end else begin
			case (kind)
				mts_pkg::K_MARCH, mts_pkg::K_FULL: begin
					a.addr = base + 32'(off);
					if (e == 3'd0) begin
						a.data = mts_pkg::PatZero;
					end else if (e == 3'd5) begin
						a.rd = 1'b1;
					end else if (s == 2'd0) begin
						a.rd   = 1'b1;
						a.data = first;
					end else begin
						a.rd   = (s == 2'd2);
						a.data = ~first;
					end
				end
				mts_pkg::K_ADDR: begin
					if (e == 3'd0) begin
						a.addr = base + 32'(bi);
					end else begin
						a.addr = base + (32'd1 << bi[4:0]);
						a.rd   = (s == 2'd1);
						a.data = (s == 2'd2) ? mts_pkg::PatZero : mts_pkg::PatOne;
					end
				end
				mts_pkg::K_DATA: begin
					a.data = 8'd1 << pi[2:0];
					a.rd   = (s == 2'd1);
				end
				default: begin
					case (s)
						2'd0: begin
							a.rd  = 1'b1;
							a.chk = 1'b0;
						end
						2'd1: a.data = mts_pkg::PatQuick;
						2'd2: begin
							a.rd   = 1'b1;
							a.data = mts_pkg::PatQuick;
						end
						default: a.data = saved;
					endcase
				end
			endcase
		end
		return a;
	endfunction

	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign in_kind  = s_tdata[2:0];
	assign in_start = s_tdata[34:3];
	assign in_size  = s_tdata[55:35];
	assign in_rdata = s_tdata[63:56];

	assign cur_op = op_of(run_kind_q, elem_q, step_q, byte_idx_q, pat_idx_q, base_q, len_q,
		saved_q);
	assign nxt_op = op_of(n_kind, n_elem, n_step, n_bidx, n_pidx, n_base, n_len, n_saved);
	assign bidx_inc = {1'b0, byte_idx_q} + 22'd1;

	always_comb begin
		n_busy      = busy_q;
		n_kind      = run_kind_q;
		n_elem      = elem_q;
		n_step      = step_q;
		n_bidx      = byte_idx_q;
		n_pidx      = pat_idx_q;
		n_base      = base_q;
		n_len       = len_q;
		n_saved     = saved_q;
		has_res     = 1'b0;
		res_cmd     = 1'b0;
		res_verdict = mts_pkg::V_PASS;
		res_fail    = '0;
		res_exp     = '0;
		res_act     = '0;
		cont        = 1'b1;
		if (!s_tuser) begin
			has_res = 1'b1;
			if (busy_q || in_start[1:0] != 2'b00 || in_size == '0 ||
				32'(in_size) > 32'(MAX_REGION_BYTES) || in_kind > 3'(mts_pkg::K_FULL)) begin
				res_verdict = mts_pkg::V_REJECT;
			end else begin
				res_cmd = 1'b1;
				n_busy  = 1'b1;
				n_kind  = in_kind;
				n_base  = in_start;
				n_len   = in_size;
				n_elem  = (in_kind == 3'(mts_pkg::K_WALK)) ? mts_pkg::WalkPhase : 3'd0;
				n_step  = '0;
				n_bidx  = '0;
				n_pidx  = '0;
				n_saved = '0;
			end
		end else if (busy_q) begin
			has_res = 1'b1;
			if (cur_op.rd && cur_op.chk && in_rdata != cur_op.data) begin
				n_busy      = 1'b0;
				res_verdict = mts_pkg::V_FAIL;
				res_fail    = cur_op.addr;
				res_exp     = cur_op.data;
				res_act     = in_rdata;
			end else begin
				if (cur_op.rd && !cur_op.chk) begin
					n_saved = in_rdata;
				end
				if (elem_q == mts_pkg::WalkPhase) begin
					if (step_q != 2'd3) begin
						n_step = step_q + 2'd1;
					end else begin
						n_step = '0;
						n_pidx = pat_idx_q + 4'd1;
						cont   = (pat_idx_q + 4'd1) < mts_pkg::NumPatterns;
					end
				end else begin
					case (run_kind_q)
						mts_pkg::K_MARCH, mts_pkg::K_FULL: begin
							if (elem_q != 3'd0 && elem_q != 3'd5 && step_q != 2'd2) begin
								n_step = step_q + 2'd1;
							end else begin
								n_step = '0;
								n_bidx = bidx_inc[20:0];
								if (bidx_inc >= {1'b0, len_q}) begin
									n_bidx = '0;
									if (elem_q != 3'd5) begin
										n_elem = elem_q + 3'd1;
									end else if (run_kind_q == 3'(mts_pkg::K_FULL)) begin
										n_elem = mts_pkg::WalkPhase;
										n_pidx = '0;
									end else begin
										cont = 1'b0;
									end
								end
							end
						end
						mts_pkg::K_ADDR: begin
							if (elem_q == 3'd0) begin
								n_bidx = bidx_inc[20:0];
								if (bidx_inc >= {1'b0, len_q}) begin
									n_bidx = '0;
									n_elem = 3'd1;
									cont   = len_q > 21'd1;
								end
							end else if (step_q != 2'd2) begin
								n_step = step_q + 2'd1;
							end else begin
								n_step = '0;
								n_bidx = bidx_inc[20:0];
								cont   = bidx_inc < 22'd32 &&
									(32'd1 << bidx_inc[4:0]) < 32'(len_q);
							end
						end
						mts_pkg::K_DATA: begin
							if (step_q == 2'd0) begin
								n_step = 2'd1;
							end else begin
								n_step = '0;
								n_pidx = pat_idx_q + 4'd1;
								cont   = (pat_idx_q + 4'd1) < mts_pkg::NumPatterns;
							end
						end
						default: begin
							if (step_q != 2'd3) begin
								n_step = step_q + 2'd1;
							end else begin
								cont = 1'b0;
							end
						end
					endcase
				end
				if (cont) begin
					res_cmd = 1'b1;
				end else begin
					n_busy = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			run_kind_q  <= '0;
			elem_q      <= '0;
			step_q      <= '0;
			byte_idx_q  <= '0;
			pat_idx_q   <= '0;
			base_q      <= '0;
			len_q       <= '0;
			saved_q     <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= '0;
			out_data_q  <= '0;
		end else if (in_acc) begin
			busy_q      <= n_busy;
			run_kind_q  <= n_kind;
			elem_q      <= n_elem;
			step_q      <= n_step;
			byte_idx_q  <= n_bidx;
			pat_idx_q   <= n_pidx;
			base_q      <= n_base;
			len_q       <= n_len;
			saved_q     <= n_saved;
			out_valid_q <= has_res;
			if (res_cmd) begin
				out_kind_q <= nxt_op.rd ? mts_pkg::OUT_READ : mts_pkg::OUT_WRITE;
				out_data_q <= {56'd0, (nxt_op.rd ? 8'd0 : nxt_op.data), nxt_op.addr};
			end else begin
				out_kind_q <= mts_pkg::OUT_VERDICT;
				out_data_q <= {6'd0, res_act, res_exp, res_fail, res_verdict, 8'd0, 32'd0};
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

	// A pending command always belongs to a running test.
	`ASSERT_CLK(a_cmd_busy, clk, arst_n,
		(out_valid_q && out_kind_q != mts_pkg::OUT_VERDICT) |-> busy_q)
	// A pass or mismatch verdict ends the test.
	`ASSERT_CLK(a_final_idle, clk, arst_n,
		(out_valid_q && out_kind_q == mts_pkg::OUT_VERDICT &&
		out_data_q[41:40] != mts_pkg::V_REJECT) |-> !busy_q)
	// The pattern walk never runs past its table.
	`ASSERT_CLK(a_walk_range, clk, arst_n,
		(busy_q && elem_q == mts_pkg::WalkPhase) |-> pat_idx_q < mts_pkg::NumPatterns)
endmodule

[tb/memory_test_sequencer_checker.sv]
// Checker that predicts the sequencer's results from its accepted items and compares them.
module memory_test_sequencer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          errors,
	output int          waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [7:0]  wdata;
		logic [1:0]  verdict;
		logic [31:0] fail_addr;
		logic [7:0]  exp_byte;
		logic [7:0]  act_byte;
	} result_t;

	result_t     expected_q[$];

	logic        busy;
	logic [2:0]  run_kind;
	logic [2:0]  elem;
	logic [1:0]  step;
	logic [20:0] idx;
	logic [3:0]  pat;
	logic [31:0] base;
	logic [20:0] len;
	logic [7:0]  pend;
	logic [7:0]  saved;

	// Works out the access that the current position of the sequence stands for.
	function automatic void current_access(output logic rd, output logic [31:0] addr,
			output logic [7:0] data, output logic chk);
		logic [31:0] off;
		logic [7:0]  first;
		rd = 1'b0;
		addr = base;
		data = mts_pkg::PatZero;
		chk = 1'b1;
		if (elem == mts_pkg::WalkPhase) begin
			data = mts_pkg::walk_pattern(pat[2:0]);
			rd = (step >= 2'd2);
			if (step[0])
				addr = base + 32'(len) - 32'd1;
			return;
		end
		case (run_kind)
			mts_pkg::K_MARCH, mts_pkg::K_FULL: begin
				off = (elem >= 3'd3) ? 32'(len) - 32'd1 - 32'(idx) : 32'(idx);
				first = (elem == 3'd2 || elem == 3'd4) ? mts_pkg::PatOne : mts_pkg::PatZero;
				addr = base + off;
				if (elem == 3'd0) begin
					data = mts_pkg::PatZero;
				end else if (elem == 3'd5) begin
					rd = 1'b1;
					data = mts_pkg::PatZero;
				end else if (step == 2'd0) begin
					rd = 1'b1;
					data = first;
				end else begin
					rd = (step == 2'd2);
					data = ~first;
				end
			end
			mts_pkg::K_ADDR: begin
				if (elem == 3'd0) begin
					addr = base + 32'(idx);
				end else begin
					addr = base + (32'd1 << idx[4:0]);
					rd = (step == 2'd1);
					data = (step == 2'd2) ? mts_pkg::PatZero : mts_pkg::PatOne;
				end
			end
			mts_pkg::K_DATA: begin
				data = 8'd1 << pat[2:0];
				rd = (step == 2'd1);
			end
			default: begin
				// Quick test: the first read saves the original byte unchecked.
				case (step)
					2'd0: begin
						rd = 1'b1;
						chk = 1'b0;
					end
					2'd1: data = mts_pkg::PatQuick;
					2'd2: begin
						rd = 1'b1;
						data = mts_pkg::PatQuick;
					end
					default: data = saved;
				endcase
			end
		endcase
	endfunction

	// Steps the sequence on; returns 0 once the test has no access left.
	function automatic bit step_on();
		logic [1:0] steps;
		if (elem == mts_pkg::WalkPhase) begin
			if (step < 2'd3) begin
				step++;
				return 1;
			end
			step = 2'd0;
			pat++;
			return pat < mts_pkg::NumPatterns;
		end
		case (run_kind)
			mts_pkg::K_MARCH, mts_pkg::K_FULL: begin
				steps = (elem == 3'd0 || elem == 3'd5) ? 2'd1 : 2'd3;
				if (step + 2'd1 < steps) begin
					step++;
					return 1;
				end
				step = 2'd0;
				idx++;
				if (idx < len)
					return 1;
				idx = '0;
				if (elem + 3'd1 < mts_pkg::WalkPhase) begin
					elem++;
					return 1;
				end
				if (run_kind == mts_pkg::K_FULL) begin
					elem = mts_pkg::WalkPhase;
					pat = '0;
					return 1;
				end
				return 0;
			end
			mts_pkg::K_ADDR: begin
				if (elem == 3'd0) begin
					idx++;
					if (idx < len)
						return 1;
					idx = '0;
					elem = 3'd1;
					return len > 21'd1;
				end
				if (step < 2'd2) begin
					step++;
					return 1;
				end
				step = 2'd0;
				idx++;
				return idx < 21'd32 && (64'd1 << idx) < 64'(len);
			end
			mts_pkg::K_DATA: begin
				if (step == 2'd0) begin
					step = 2'd1;
					return 1;
				end
				step = 2'd0;
				pat++;
				return pat < 4'd8;
			end
			default: begin
				if (step < 2'd3) begin
					step++;
					return 1;
				end
				return 0;
			end
		endcase
	endfunction

	function automatic result_t verdict_of(logic [1:0] v, logic [31:0] fa, logic [7:0] ex,
			logic [7:0] ac);
		result_t r;
		r.kind = mts_pkg::OUT_VERDICT;
		r.addr = '0;
		r.wdata = '0;
		r.verdict = v;
		r.fail_addr = fa;
		r.exp_byte = ex;
		r.act_byte = ac;
		return r;
	endfunction

	function automatic result_t command_now();
		result_t     r;
		logic        rd;
		logic        chk;
		logic [31:0] addr;
		logic [7:0]  data;
		current_access(rd, addr, data, chk);
		pend = data;
		r = verdict_of(mts_pkg::V_PASS, '0, '0, '0);
		r.kind = rd ? mts_pkg::OUT_READ : mts_pkg::OUT_WRITE;
		r.addr = addr;
		r.wdata = rd ? 8'd0 : data;
		return r;
	endfunction

	// Predicts the result of one accepted item; returns 0 where the item yields none.
	function automatic bit predict_access(input logic op, input logic [2:0] tk,
			input logic [31:0] start, input logic [20:0] size, input logic [7:0] rdata,
			output result_t r);
		logic        rd;
		logic        chk;
		logic [31:0] addr;
		logic [7:0]  data;
		if (!op) begin
			if (busy || start[1:0] != 2'b00 || size == '0
					|| size > 21'(mts_pkg::MaxRegionBytes)
					|| tk > mts_pkg::K_FULL) begin
				r = verdict_of(mts_pkg::V_REJECT, '0, '0, '0);
				return 1;
			end
			busy = 1'b1;
			run_kind = tk;
			base = start;
			len = size;
			elem = (tk == mts_pkg::K_WALK) ? mts_pkg::WalkPhase : 3'd0;
			step = '0;
			idx = '0;
			pat = '0;
			saved = '0;
			r = command_now();
			return 1;
		end
		if (!busy)
			return 0;
		current_access(rd, addr, data, chk);
		if (rd) begin
			if (!chk) begin
				saved = rdata;
			end else if (rdata != pend) begin
				busy = 1'b0;
				r = verdict_of(mts_pkg::V_FAIL, addr, pend, rdata);
				return 1;
			end
		end
		if (!step_on()) begin
			busy = 1'b0;
			r = verdict_of(mts_pkg::V_PASS, '0, '0, '0);
			return 1;
		end
		r = command_now();
		return 1;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		if (errors < 40)
			$display("ERROR @%0t: %s is %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		result_t pred;
		if (!arst_n) begin
			busy = 1'b0;
			run_kind = '0;
			elem = '0;
			step = '0;
			idx = '0;
			pat = '0;
			base = '0;
			len = '0;
			pend = '0;
			saved = '0;
			expected_q.delete();
			errors = 0;
			waiting = 0;
		end else begin
			// The output register delays each result, so compare before predicting.
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.addr = m_tdata[31:0];
				got.wdata = m_tdata[39:32];
				got.verdict = m_tdata[41:40];
				got.fail_addr = m_tdata[73:42];
				got.exp_byte = m_tdata[81:74];
				got.act_byte = m_tdata[89:82];
				if (expected_q.size() == 0) begin
					report("unexpected result, kind", 32'(got.kind), 32'(got.kind));
				end else begin
					want = expected_q.pop_front();
					if (got.kind != want.kind)
						report("kind", 32'(got.kind), 32'(want.kind));
					if (got.addr != want.addr)
						report("access_addr", got.addr, want.addr);
					if (got.wdata != want.wdata)
						report("write_data", 32'(got.wdata), 32'(want.wdata));
					if (got.verdict != want.verdict)
						report("verdict", 32'(got.verdict), 32'(want.verdict));
					if (got.fail_addr != want.fail_addr)
						report("fail_addr", got.fail_addr, want.fail_addr);
					if (got.exp_byte != want.exp_byte)
						report("expected_byte", 32'(got.exp_byte), 32'(want.exp_byte));
					if (got.act_byte != want.act_byte)
						report("actual_byte", 32'(got.act_byte), 32'(want.act_byte));
				end
			end
			if (s_tvalid && s_tready) begin
				if (predict_access(s_tuser, s_tdata[2:0], s_tdata[34:3], s_tdata[55:35],
						s_tdata[63:56], pred))
					expected_q.push_back(pred);
			end
			waiting = expected_q.size();
		end
	end
endmodule

[tb/memory_test_sequencer_test.sv]
// Top of the sequencer testbench: clock, reset, stimulus, memory responder and verdict.
module memory_test_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] BadKindLow  = 3'd6;
	localparam logic [2:0] BadKindHigh = 3'd7;
	localparam logic       OpStart     = 1'b0;
	localparam logic       OpAck       = 1'b1;
	localparam int         CycleLimit  = 2000000;
	localparam int         ItemTarget  = 1300;

	// One result item as the responder sees it.
	typedef struct {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [7:0]  wdata;
		logic [1:0]  verdict;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [1:0]  m_tuser;
	int          errors;
	int          waiting;

	int          cycles = 0;
	int          hold_end = 0;
	int          items_sent = 0;
	bit          tx_burst = 1'b0;
	bit          rx_burst = 1'b0;
	int          rx_stall = 0;
	reply_t      reply_q[$];
	// Memory contents as the test has left them, byte by byte.
	logic [7:0]  mem[logic [31:0]];

	memory_test_sequencer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	memory_test_sequencer_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.errors  (errors),
		.waiting (waiting)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// The cycle count also bounds the run in case the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver side: random stalls per item, bursts without stalls, and long hold-offs
	// requested by the stimulus through hold_end. Accepted results go to the responder.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			reply_q.push_back('{m_tuser, m_tdata[31:0], m_tdata[39:32], m_tdata[41:40]});
			if ($urandom_range(0, 59) == 0)
				rx_burst = ~rx_burst;
			rx_stall = rx_burst ? 0 : $urandom_range(0, 19);
		end else if (rx_stall > 0) begin
			rx_stall--;
		end
		m_tready <= arst_n && rx_stall == 0 && cycles >= hold_end;
	end

	// Offers one item after a random gap and returns at the edge that accepts it. Valid
	// stays high afterwards so that a following item can go out back to back.
	task automatic send_item(input logic op, input logic [2:0] tk, input logic [31:0] start,
			input logic [20:0] size, input logic [7:0] rdata);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {rdata, size, start, tk};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Lowers valid and waits for the next result item.
	task automatic next_reply(output reply_t r);
		s_tvalid <= 1'b0;
		while (reply_q.size() == 0)
			@(posedge clk);
		r = reply_q.pop_front();
	endtask

	// Pauses the sender until every predicted result has been taken.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
		reply_q.delete();
	endtask

	function automatic logic [31:0] rand_base();
		if ($urandom_range(0, 7) == 0)
			return 32'hFFFF_FFFC - 32'(4 * $urandom_range(0, 3));
		return $urandom() & 32'hFFFF_FFFC;
	endfunction

	// Runs one accepted test, acting as the memory. A read is answered from the memory
	// image and corrupted with a chance of one in corrupt_odds (never when zero). Now and
	// then a second, valid start goes in while the test runs, which must be rejected.
	task automatic run_test(input logic [2:0] tk, input logic [31:0] start,
			input logic [20:0] size, input int corrupt_odds);
		reply_t     r;
		logic [7:0] rdata;
		int         busy_rejects;
		busy_rejects = 0;
		send_item(OpStart, tk, start, size, 8'($urandom()));
		forever begin
			next_reply(r);
			if (r.kind == mts_pkg::OUT_VERDICT) begin
				if (r.verdict == mts_pkg::V_REJECT && busy_rejects > 0) begin
					busy_rejects--;
					continue;
				end
				break;
			end
			if ($urandom_range(0, 39) == 0) begin
				send_item(OpStart, 3'($urandom_range(0, 5)), rand_base(), 21'd4, 8'd0);
				busy_rejects++;
			end
			rdata = 8'($urandom());
			if (r.kind == mts_pkg::OUT_WRITE) begin
				mem[r.addr] = r.wdata;
			end else begin
				if (!mem.exists(r.addr))
					mem[r.addr] = rdata;
				rdata = mem[r.addr];
				if (corrupt_odds > 0 && $urandom_range(1, corrupt_odds) == 1)
					rdata ^= 8'($urandom_range(1, 255));
			end
			send_item(OpAck, 3'($urandom()), $urandom(), 21'($urandom()), rdata);
		end
	endtask

	// Sends a start that breaks at least one rule and waits for its rejection.
	task automatic bad_start(input logic [2:0] tk, input logic [31:0] start,
			input logic [20:0] size);
		reply_t r;
		send_item(OpStart, tk, start, size, 8'($urandom()));
		next_reply(r);
	endtask

	task automatic idle_acks(input int count);
		repeat (count)
			send_item(OpAck, 3'($urandom()), $urandom(), 21'($urandom()), 8'($urandom()));
		drain();
	endtask

	initial begin
		logic [2:0]  tk;
		logic [31:0] start;
		logic [20:0] size;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: every rejection rule of an idle block, idle acknowledges, and each test kind,
		// including address wrap at the top of the space, a one-byte region, the largest
		// region and a forced mismatch in the quick test.
		bad_start(mts_pkg::K_MARCH, 32'h0000_1001, 21'd4);
		bad_start(mts_pkg::K_WALK, 32'hFFFF_FFFE, 21'd4);
		bad_start(mts_pkg::K_QUICK, 32'h0000_0003, 21'd4);
		bad_start(mts_pkg::K_DATA, 32'h0000_0000, 21'd0);
		bad_start(mts_pkg::K_DATA, 32'h0000_0100, 21'(mts_pkg::MaxRegionBytes + 1));
		bad_start(mts_pkg::K_ADDR, 32'h0000_0100, 21'h1F_FFFF);
		bad_start(BadKindLow, 32'h0000_0100, 21'd4);
		bad_start(BadKindHigh, 32'h0000_0100, 21'd4);
		idle_acks(2);
		run_test(mts_pkg::K_MARCH, 32'h0000_0000, 21'd3, 0);
		run_test(mts_pkg::K_WALK, 32'hFFFF_FFFC, 21'd8, 0);
		run_test(mts_pkg::K_WALK, 32'h0000_0040, 21'd1, 0);
		run_test(mts_pkg::K_ADDR, 32'h0000_0200, 21'd9, 0);
		run_test(mts_pkg::K_ADDR, 32'h0000_0300, 21'd1, 0);
		run_test(mts_pkg::K_DATA, 32'hFFFF_FFFC, 21'(mts_pkg::MaxRegionBytes), 0);
		run_test(mts_pkg::K_QUICK, 32'h0000_0400, 21'd4, 0);
		run_test(mts_pkg::K_QUICK, 32'h0000_0400, 21'd4, 1);
		run_test(mts_pkg::K_FULL, 32'h0000_0500, 21'd2, 0);
		run_test(mts_pkg::K_MARCH, 32'h0000_0600, 21'd4, 20);
		drain();

		// Receiver holds off for a long stretch while rejected starts keep coming, so the
		// output register fills and the input stalls. The sender then waits it out.
		hold_end = cycles + 300;
		tx_burst = 1'b1;
		repeat (12)
			send_item(OpStart, BadKindHigh, $urandom(), 21'($urandom()), 8'($urandom()));
		drain();

		while (items_sent < ItemTarget) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 29) == 0)
				hold_end = cycles + $urandom_range(50, 150);
			start = rand_base();
			size = ($urandom_range(0, 9) < 2) ? 21'($urandom_range(13, 24))
				: 21'($urandom_range(1, 12));
			case ($urandom_range(0, 9))
				0: begin
					tk = 3'($urandom());
					size = 21'($urandom());
					case ($urandom_range(0, 3))
						0: start = $urandom() | 32'($urandom_range(1, 3));
						1: size = '0;
						2: size = 21'($urandom_range(mts_pkg::MaxRegionBytes + 1,
							21'h1F_FFFF));
						default: tk = 3'($urandom_range(BadKindLow, BadKindHigh));
					endcase
					bad_start(tk, start, size);
				end
				1: idle_acks($urandom_range(1, 3));
				default: begin
					run_test(3'($urandom_range(0, 5)), start, size,
						($urandom_range(0, 1) == 0) ? 0 : 150);
				end
			endcase
			drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

[files.f]
+incdir+design
design/mts_pkg.sv
design/memory_test_sequencer.sv
tb/memory_test_sequencer_checker.sv
tb/memory_test_sequencer_test.sv
